// ----- rtl/core/mmi_pkg.sv -----
// Shared widths, register indexes and pipeline tag type of the matrix multiplier.
`default_nettype none
package mmi_pkg;

  localparam int unsigned MAX_DIM_DEF = 8;

  localparam int unsigned ELEM_W    = 16;  // input element
  localparam int unsigned PROD_W    = 36;  // product element
  localparam int unsigned POS_W     = 3;   // out_row / out_col
  localparam int unsigned CFG_W     = 4;   // configuration data
  localparam int unsigned CFG_IDX_W = 4;   // configuration register index

  localparam logic [CFG_IDX_W-1:0] REG_ROWS_FIRST  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_FIRST  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_SECOND = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_SECOND = 4'd3;

  // Travels with each multiply-accumulate step.
  typedef struct packed {
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             first_k;    // clear accumulator
    logic             last_k;     // sum complete after this step
    logic             last_elem;  // final product element of the run
  } mmi_tag_t;

endpackage
`default_nettype wire

// ----- rtl/core/mmi_in_if.sv -----
// Input element channel.
`default_nettype none
interface mmi_in_if;
  import mmi_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [ELEM_W-1:0] element;

  modport source (output valid, output element, input ready);
  modport sink   (input valid, input element, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/mmi_out_if.sv -----
// Product result channel.
`default_nettype none
interface mmi_out_if;
  import mmi_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [PROD_W-1:0] product;
  logic [POS_W-1:0]         out_row;
  logic [POS_W-1:0]         out_col;
  logic                     last;
  logic                     not_possible;

  modport source (output valid, output product, output out_row, output out_col,
                  output last, output not_possible, input ready);
  modport sink   (input valid, input product, input out_row, input out_col,
                  input last, input not_possible, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/mmi_cfg_if.sv -----
// Configuration write channel.
`default_nettype none
interface mmi_cfg_if;
  import mmi_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/mmi_mac.sv -----
// Multiply-accumulate unit: registered product, then running sum.
`default_nettype none
module mmi_mac (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             en_i,
  input  wire logic                             valid_i,
  input  wire logic signed [mmi_pkg::ELEM_W-1:0] a_i,
  input  wire logic signed [mmi_pkg::ELEM_W-1:0] b_i,
  input  wire mmi_pkg::mmi_tag_t                tag_i,
  output logic                                  valid_o,
  output logic signed [mmi_pkg::PROD_W-1:0]     sum_o,
  output mmi_pkg::mmi_tag_t                     tag_o
);
  import mmi_pkg::*;

  logic                       v_q;
  mmi_tag_t                   tag_q;
  logic signed [2*ELEM_W-1:0] prod_q;
  logic signed [PROD_W-1:0]   acc_q;
  logic signed [PROD_W-1:0]   sum_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en_i) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tag_q  <= tag_i;
      prod_q <= a_i * b_i;
    end
    if (en_i && v_q) begin
      acc_q <= sum_d;
    end
  end

  // Sign-extended product onto the running sum; restart on the first term.
  assign sum_d = (tag_q.first_k ? PROD_W'(0) : acc_q) + PROD_W'(prod_q);

  assign valid_o = v_q;
  assign sum_o   = sum_d;
  assign tag_o   = tag_q;
endmodule
`default_nettype wire

// ----- rtl/core/matrix_multiply_int.sv -----
// Integer matrix multiplier: load two matrices into memories, then stream the product.
// Loading: one element a cycle while the output register is free; no result while loading.
// Compute: rows_first*cols_second*cols_first MAC steps, one a cycle while the output register
//   is free, through the registered memory reads, the MAC product register and the output register.
// Dimension mismatch: each element gives one not_possible word, same cycle rate as loading.
// Reset: sizes return to 1, load position to the first matrix; stores hold no defined data.
`default_nettype none
module matrix_multiply_int #(
  parameter int unsigned MAX_DIM = mmi_pkg::MAX_DIM_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  mmi_in_if.sink     in_i,
  mmi_out_if.source  out_o,
  mmi_cfg_if.sink    cfg_i
);
  import mmi_pkg::*;

  localparam int unsigned DEPTH = MAX_DIM * MAX_DIM;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;   // store address
  localparam int unsigned CW    = $clog2(DEPTH + 1);                 // load count
  localparam int unsigned IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1; // loop index
  localparam int unsigned DW    = $clog2(MAX_DIM + 1);               // used dimension

  // Sequencer states
  localparam logic [1:0] ST_LOAD  = 2'd0;
  localparam logic [1:0] ST_ISSUE = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  // A zero size counts as one, anything above MAX_DIM as MAX_DIM.
  function automatic logic [DW-1:0] used_dim(input logic [CFG_W-1:0] v);
    logic [DW-1:0] r;
    if (v == CFG_W'(0)) begin
      r = DW'(1);
    end else if (v > CFG_W'(MAX_DIM)) begin
      r = DW'(MAX_DIM);
    end else begin
      r = DW'(v);
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- config
  logic [CFG_W-1:0] rows_first_q, cols_first_q, rows_second_q, cols_second_q;
  logic             cfg_we;
  logic             cfg_hit;

  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid;

  always_comb begin
    unique case (cfg_i.index)
      REG_ROWS_FIRST, REG_COLS_FIRST, REG_ROWS_SECOND, REG_COLS_SECOND: cfg_hit = 1'b1;
      default: cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_first_q  <= CFG_W'(1);
      cols_first_q  <= CFG_W'(1);
      rows_second_q <= CFG_W'(1);
      cols_second_q <= CFG_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_i.index)
        REG_ROWS_FIRST:  rows_first_q  <= cfg_i.data;
        REG_COLS_FIRST:  cols_first_q  <= cfg_i.data;
        REG_ROWS_SECOND: rows_second_q <= cfg_i.data;
        REG_COLS_SECOND: cols_second_q <= cfg_i.data;
        default: ;  // index beyond the list: ignored
      endcase
    end
  end

  logic [DW-1:0] dim_m, dim_n, dim_p, dim_q;
  logic [CW-1:0] size_first, size_second;
  logic          mismatch;

  assign dim_m       = used_dim(rows_first_q);
  assign dim_n       = used_dim(cols_first_q);
  assign dim_p       = used_dim(rows_second_q);
  assign dim_q       = used_dim(cols_second_q);
  assign size_first  = CW'(dim_m) * CW'(dim_n);
  assign size_second = CW'(dim_p) * CW'(dim_q);
  assign mismatch    = (dim_n != dim_p);

  // ---------------------------------------------------------------- control
  logic [1:0]    state_q, state_d;
  logic [CW-1:0] load_count_q, load_count_d, load_inc;
  logic          loading_second_q, loading_second_d;
  logic [IW-1:0] ci_q, cj_q, ck_q, ci_d, cj_d, ck_d;
  logic          out_valid_q;
  logic          en;          // whole compute pipeline advances
  logic          in_acc;
  logic          ci_end, cj_end, ck_end;
  logic          mac_v;
  mmi_tag_t      mac_tag;
  logic signed [PROD_W-1:0] mac_sum;
  logic          done_word;   // final product word enters the output register

  // Only an occupied output register that is not drained holds things up.
  assign en          = !(out_valid_q && !out_o.ready);
  assign in_i.ready  = (state_q == ST_LOAD) && en;
  assign in_acc      = in_i.valid && in_i.ready;
  assign load_inc    = load_count_q + CW'(1);

  assign ci_end = (DW'(ci_q) == dim_m - DW'(1));
  assign cj_end = (DW'(cj_q) == dim_q - DW'(1));
  assign ck_end = (DW'(ck_q) == dim_n - DW'(1));

  assign done_word = en && mac_v && mac_tag.last_k && mac_tag.last_elem;

  always_comb begin
    state_d          = state_q;
    load_count_d     = load_count_q;
    loading_second_d = loading_second_q;
    ci_d             = ci_q;
    cj_d             = cj_q;
    ck_d             = ck_q;
    unique case (state_q)
      ST_LOAD: begin
        if (in_acc && !mismatch) begin
          if (!loading_second_q) begin
            if (load_inc >= size_first) begin
              load_count_d     = '0;
              loading_second_d = 1'b1;
            end else begin
              load_count_d = load_inc;
            end
          end else if (load_inc >= size_second) begin
            load_count_d     = '0;
            loading_second_d = 1'b0;
            ci_d             = '0;
            cj_d             = '0;
            ck_d             = '0;
            state_d          = ST_ISSUE;
          end else begin
            load_count_d = load_inc;
          end
        end
      end
      ST_ISSUE: begin
        // k innermost, then column, then row
        if (en) begin
          if (!ck_end) begin
            ck_d = ck_q + IW'(1);
          end else begin
            ck_d = '0;
            if (!cj_end) begin
              cj_d = cj_q + IW'(1);
            end else begin
              cj_d = '0;
              if (!ci_end) begin
                ci_d = ci_q + IW'(1);
              end else begin
                state_d = ST_DRAIN;
              end
            end
          end
        end
      end
      ST_DRAIN: begin
        if (done_word) begin
          state_d = ST_LOAD;
        end
      end
      default: state_d = ST_LOAD;
    endcase
    // a write to a size register restarts loading (to be done only while idle; the block does not enforce it)
    if (cfg_we && cfg_hit) begin
      load_count_d     = '0;
      loading_second_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= ST_LOAD;
      load_count_q     <= '0;
      loading_second_q <= 1'b0;
      ci_q             <= '0;
      cj_q             <= '0;
      ck_q             <= '0;
    end else begin
      state_q          <= state_d;
      load_count_q     <= load_count_d;
      loading_second_q <= loading_second_d;
      ci_q             <= ci_d;
      cj_q             <= cj_d;
      ck_q             <= ck_d;
    end
  end

  // ---------------------------------------------------------------- stores
  // Loads and compute reads sit in separate phases, so no forwarding is needed.
  logic signed [ELEM_W-1:0] first_mem  [DEPTH];
  logic signed [ELEM_W-1:0] second_mem [DEPTH];
  logic signed [ELEM_W-1:0] a_rd_q, b_rd_q;
  logic [CW-1:0]            a_lin, b_lin;
  logic [AW-1:0]            a_addr, b_addr, w_addr;
  logic                     we_first, we_second;
  logic                     issue;

  assign we_first  = in_acc && !mismatch && !loading_second_q;
  assign we_second = in_acc && !mismatch && loading_second_q;
  assign w_addr    = AW'(load_count_q);
  assign a_lin     = CW'(ci_q) * CW'(dim_n) + CW'(ck_q);   // i*n + k
  assign b_lin     = CW'(ck_q) * CW'(dim_q) + CW'(cj_q);   // k*q + j
  assign a_addr    = AW'(a_lin);
  assign b_addr    = AW'(b_lin);
  assign issue     = (state_q == ST_ISSUE);

  always_ff @(posedge clk_i) begin
    if (we_first) begin
      first_mem[w_addr] <= in_i.element;
    end
    if (en) begin
      a_rd_q <= first_mem[a_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_second) begin
      second_mem[w_addr] <= in_i.element;
    end
    if (en) begin
      b_rd_q <= second_mem[b_addr];
    end
  end

  // tag for the word being read this cycle
  logic     rd_v_q;
  mmi_tag_t rd_tag_q, issue_tag;

  always_comb begin
    issue_tag.row       = POS_W'(ci_q);
    issue_tag.col       = POS_W'(cj_q);
    issue_tag.first_k   = (ck_q == '0);
    issue_tag.last_k    = ck_end;
    issue_tag.last_elem = ci_end && cj_end;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q <= 1'b0;
    end else if (en) begin
      rd_v_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rd_tag_q <= issue_tag;
    end
  end

  mmi_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (rd_v_q),
    .a_i     (a_rd_q),
    .b_i     (b_rd_q),
    .tag_i   (rd_tag_q),
    .valid_o (mac_v),
    .sum_o   (mac_sum),
    .tag_o   (mac_tag)
  );

  // ---------------------------------------------------------------- output word
  logic signed [PROD_W-1:0] product_q;
  logic [POS_W-1:0]         row_q, col_q;
  logic                     last_q, np_q;
  logic                     word_load, np_load;

  assign word_load = en && mac_v && mac_tag.last_k;
  assign np_load   = in_acc && mismatch;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (word_load || np_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (word_load) begin
      product_q <= mac_sum;
      row_q     <= mac_tag.row;
      col_q     <= mac_tag.col;
      last_q    <= mac_tag.last_elem;
      np_q      <= 1'b0;
    end else if (np_load) begin
      product_q <= '0;
      row_q     <= '0;
      col_q     <= '0;
      last_q    <= 1'b0;
      np_q      <= 1'b1;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.product      = product_q;
  assign out_o.out_row      = row_q;
  assign out_o.out_col      = col_q;
  assign out_o.last         = last_q;
  assign out_o.not_possible = np_q;

endmodule
`default_nettype wire

// ----- dv/tb.sv -----
// Testbench for matrix_multiply_int: random and directed matrix loads checked against a predictor.
`timescale 1ns / 100ps
module tb;
  import mmi_pkg::*;

  localparam int unsigned SIDE_MAX      = MAX_DIM_DEF;
  localparam int unsigned STORE_DEPTH   = SIDE_MAX * SIDE_MAX;
  localparam int unsigned ITEM_TARGET   = 310;
  localparam int unsigned SETTLE_CYCLES = 16;     // block may still be absorbing a loaded word
  localparam int unsigned TAIL_CYCLES   = 64;     // catch stray words after the last one
  localparam int unsigned CYCLE_LIMIT   = 500000;

  // Index past the four size registers; a write there must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 4'd9;

  // One word of the product stream.
  typedef struct {
    logic signed [PROD_W-1:0] product;
    logic [POS_W-1:0]         row;
    logic [POS_W-1:0]         col;
    logic                     last;
    logic                     not_possible;
  } product_word_t;

  // Receiver back-pressure patterns.
  typedef enum {RX_STREAM, RX_COIN, RX_SPARSE} rx_pattern_t;

  // Keeps a copy of the size registers and both matrix stores, predicts the
  // product words for every accepted element and checks the words that come out.
  class product_tracker;
    logic [CFG_W-1:0]         size_reg [4];
    logic signed [ELEM_W-1:0] first_mat [STORE_DEPTH];
    logic signed [ELEM_W-1:0] second_mat [STORE_DEPTH];
    int unsigned              fill_pos;
    bit                       on_second;
    product_word_t            pending_words [$];
    int unsigned              faults;
    int unsigned              products_seen;
    int unsigned              refusals_seen;

    function new();
      foreach (size_reg[r]) size_reg[r] = 1;
      fill_pos  = 0;
      on_second = 0;
    endfunction

    // Register value as the block uses it: 0 acts as 1, above the max acts as the max.
    function int unsigned used_size(logic [CFG_W-1:0] v);
      if (v == 0) return 1;
      if (v > SIDE_MAX) return SIDE_MAX;
      return v;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      if (idx > REG_COLS_SECOND) return;
      size_reg[idx] = val;
      fill_pos      = 0;
      on_second     = 0;
    endfunction

    function void note_element(logic signed [ELEM_W-1:0] e);
      int unsigned   m, n, p, q;
      longint        acc;
      product_word_t w;
      m = used_size(size_reg[REG_ROWS_FIRST]);
      n = used_size(size_reg[REG_COLS_FIRST]);
      p = used_size(size_reg[REG_ROWS_SECOND]);
      q = used_size(size_reg[REG_COLS_SECOND]);
      if (n != p) begin
        // inner sizes differ: one refusal per element, nothing stored
        w = '{product: '0, row: '0, col: '0, last: 1'b0, not_possible: 1'b1};
        pending_words.push_back(w);
        return;
      end
      if (!on_second) begin
        first_mat[fill_pos % STORE_DEPTH] = e;
        fill_pos++;
        if (fill_pos >= m * n) begin
          fill_pos  = 0;
          on_second = 1;
        end
        return;
      end
      second_mat[fill_pos % STORE_DEPTH] = e;
      fill_pos++;
      if (fill_pos < p * q) return;
      fill_pos  = 0;
      on_second = 0;
      for (int i = 0; i < m; i++) begin
        for (int j = 0; j < q; j++) begin
          acc = 0;
          for (int k = 0; k < n; k++)
            acc += longint'(first_mat[i * n + k]) * longint'(second_mat[k * q + j]);
          w.product      = acc[PROD_W-1:0];
          w.row          = POS_W'(i);
          w.col          = POS_W'(j);
          w.last         = (i == m - 1) && (j == q - 1);
          w.not_possible = 1'b0;
          pending_words.push_back(w);
        end
      end
    endfunction

    function void compare(string field, logic signed [63:0] want, logic signed [63:0] got);
      if (want !== got) begin
        faults++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
    endfunction

    function void check_word(logic signed [PROD_W-1:0] product, logic [POS_W-1:0] row,
                             logic [POS_W-1:0] col, logic last, logic not_possible);
      product_word_t want;
      if (not_possible) refusals_seen++;
      else products_seen++;
      if (pending_words.size() == 0) begin
        faults++;
        $display("%0t: word with nothing expected, actual product %0d row %0d col %0d np %0b",
                 $time, product, row, col, not_possible);
        return;
      end
      want = pending_words.pop_front();
      compare("product", want.product, product);
      compare("out_row", want.row, row);
      compare("out_col", want.col, col);
      compare("last", want.last, last);
      compare("not_possible", want.not_possible, not_possible);
    endfunction

    function int unsigned pending();
      return pending_words.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  mmi_in_if  in_if ();
  mmi_out_if out_if ();
  mmi_cfg_if cfg_if ();

  matrix_multiply_int DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if.sink),
    .out_o  (out_if.source),
    .cfg_i  (cfg_if.sink)
  );

  product_tracker tracker = new();

  int unsigned items_sent;
  int unsigned settings_applied;
  int unsigned burst_left;
  int unsigned cycle_count;
  int unsigned rx_left;
  int unsigned rx_phase;
  rx_pattern_t rx_mode;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Run guard: a hung handshake or a missing word ends here.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Receiver: switches between streaming, coin-flip stalls and a sparse
  // one-in-four pattern, each held for a random stretch.
  always @(negedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = rx_pattern_t'($urandom_range(0, 2));
      rx_left = $urandom_range(4, 40);
    end
    rx_left--;
    rx_phase++;
    case (rx_mode)
      RX_STREAM: begin
        out_if.ready <= 1'b1;
      end
      RX_COIN: begin
        out_if.ready <= 1'($urandom_range(0, 1));
      end
      default: begin
        out_if.ready <= (rx_phase % 4 == 3);
      end
    endcase
  end

  // Output words are sampled at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid === 1'b1 && out_if.ready === 1'b1)
      tracker.check_word(out_if.product, out_if.out_row, out_if.out_col, out_if.last,
                         out_if.not_possible);
  end

  // Extremes show up often; the rest is uniform over all 16 bits.
  function automatic logic signed [ELEM_W-1:0] pick_element();
    case ($urandom_range(0, 15))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return '0;
      3:       return '1;
      default: return ELEM_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // Mostly small sides keep runs short; full size shows up now and then.
  function automatic int unsigned pick_size();
    if ($urandom_range(0, 11) == 0) return SIDE_MAX;
    return $urandom_range(1, 4);
  endfunction

  // Register encoding for a side: 0 may stand for 1, anything above the max for the max.
  function automatic logic [CFG_W-1:0] raw_size(int unsigned side);
    if (side == 1 && $urandom_range(0, 3) == 0) return '0;
    if (side == SIDE_MAX && $urandom_range(0, 1) == 1)
      return CFG_W'($urandom_range(SIDE_MAX + 1, (1 << CFG_W) - 1));
    return CFG_W'(side);
  endfunction

  // Sender: bursts of random length, random gaps in between. Called at a falling edge,
  // returns at the falling edge after the word was taken, valid still high.
  task automatic send_element(input logic signed [ELEM_W-1:0] e);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
      gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_if.valid   <= 1'b1;
    in_if.element <= e;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    tracker.note_element(e);
    items_sent++;
    @(negedge clk_i);
  endtask

  // Drop valid and hold off until every predicted word has arrived.
  task automatic wait_results_done();
    in_if.valid <= 1'b0;
    while (tracker.pending() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // One register write; hold keeps valid up for a back-to-back write.
  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val,
                           input bit hold);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
    tracker.write_reg(idx, val);
    @(negedge clk_i);
    if (!hold) cfg_if.valid <= 1'b0;
  endtask

  task automatic program_sizes(input logic [CFG_W-1:0] rows_a, input logic [CFG_W-1:0] cols_a,
                               input logic [CFG_W-1:0] rows_b, input logic [CFG_W-1:0] cols_b);
    wait_results_done();
    write_cfg(REG_ROWS_FIRST, rows_a, 1'b1);
    write_cfg(REG_COLS_FIRST, cols_a, 1'b1);
    write_cfg(REG_ROWS_SECOND, rows_b, 1'b1);
    write_cfg(REG_COLS_SECOND, cols_b, 1'b0);
    settings_applied++;
  endtask

  // One random phase: new sizes, then whole loads, a refusal burst, or a cut-off load.
  task automatic random_phase();
    int unsigned m, n, p, q, runs, load_len, cut;
    if ($urandom_range(0, 9) == 0) begin
      // inner sizes differ on purpose
      m = pick_size();
      q = pick_size();
      n = $urandom_range(1, SIDE_MAX);
      p = ((n - 1 + $urandom_range(1, SIDE_MAX - 1)) % SIDE_MAX) + 1;
      program_sizes(raw_size(m), raw_size(n), raw_size(p), raw_size(q));
      repeat ($urandom_range(1, 6)) send_element(pick_element());
    end else begin
      m = pick_size();
      n = pick_size();
      q = pick_size();
      program_sizes(raw_size(m), raw_size(n), raw_size(n), raw_size(q));
      load_len = m * n + n * q;
      runs     = $urandom_range(1, 3);
      for (int r = 0; r < runs && items_sent < ITEM_TARGET; r++) begin
        // sometimes let the whole product drain before the next load
        if (r != 0 && $urandom_range(0, 3) == 0) wait_results_done();
        repeat (load_len) send_element(pick_element());
      end
      // broken sequence: the next size write must restart loading
      if ($urandom_range(0, 5) == 0) begin
        cut = $urandom_range(1, load_len - 1);
        repeat (cut) send_element(pick_element());
      end
    end
  endtask

  initial begin
    in_if.valid   = 1'b0;
    in_if.element = '0;
    cfg_if.valid  = 1'b0;
    cfg_if.index  = '0;
    cfg_if.data   = '0;
    out_if.ready  = 1'b0;
    rst_ni        = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset sizes are 1x1: most negative element squared.
    send_element(16'sh8000);
    send_element(16'sh8000);

    // 2x3 times 2x1: every element refused.
    program_sizes(4'd2, 4'd3, 4'd2, 4'd1);
    send_element(16'sh7fff);
    send_element(-16'sd1);

    // Out-of-range encodings: 0 acts as 1, 12 as the max; 1x1 times 1x8.
    program_sizes(4'd0, 4'd0, 4'd1, 4'd12);
    send_element(16'sh7fff);
    send_element(16'sh8000);
    send_element(16'sh7fff);
    send_element('0);
    send_element(-16'sd1);
    repeat (4) send_element(pick_element());

    // 2x2 times 2x2 with a partial load, an ignored write past the register list
    // (loading goes on), then a real write that restarts loading.
    program_sizes(4'd2, 4'd2, 4'd2, 4'd2);
    repeat (3) send_element(pick_element());
    wait_results_done();
    write_cfg(REG_UNUSED, 4'd5, 1'b0);
    send_element(pick_element());
    wait_results_done();
    write_cfg(REG_COLS_SECOND, 4'd2, 1'b0);
    repeat (8) send_element(pick_element());

    while (items_sent < ITEM_TARGET) random_phase();

    wait_results_done();
    repeat (TAIL_CYCLES) @(negedge clk_i);

    $display("Run covered %0d elements over %0d size settings, with restarts and refusals.",
             items_sent, settings_applied);
    $display("Checked %0d product words and %0d refusal words; %0d faults.",
             tracker.products_seen, tracker.refusals_seen, tracker.faults);
    if (tracker.faults == 0 && tracker.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
